@@ design/spq_pkg.sv @@
// Shared types and codes for the pending signal queue.
// Holds the item structs, operation codes, register indexes and sequencer states.
// Has no dependencies; the core and the checker use it.
package spq_pkg;

    localparam int SIG_W     = 5;
    localparam int TOTAL_W   = 4;
    localparam int OP_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_QUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic REG_IGNORE_MASK = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SIG_W-1:0] signal_number;
    } in_item_t;

    typedef struct packed {
        logic               queued;
        logic [SIG_W-1:0]   taken_signal;
        logic               has_pending;
        logic [TOTAL_W-1:0] pending_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

@@ design/spq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the entries of the pending signal queue; no dependencies.
module spq_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/signal_pending_queue_core.sv @@
// Top level of the pending signal queue: APB register, sequencer and entry RAM.
// Depends on spq_pkg and spq_ram.
//
// Usage:
// Items arrive on the s_ channel (valid/ready) carrying an operation and a
// signal number; each item yields exactly one result item on the m_ channel.
// The ignore mask is to be written over the APB port only while the block is
// idle; the user is bound by this and the block itself does not enforce it.
// Entries live in a circular buffer in a small RAM; one sequencer reads them
// through the RAM's single read port, one entry per cycle while it scans.
// A query scans the queue. A queue item scans it and then stores the signal
// if it is in range, not yet queued and the queue has room. A take first
// removes entries from the head, passing over masked signals, until it has
// removed an unmasked one or finds the queue empty, and then scans.
// The block takes one item at a time: s_ready is high only in the idle state.
// A finished result waits in the output register, so a new item can be taken
// while the receiver holds m_ready low; a second result waits until the
// first has been taken.
// After reset the queue is empty, the ignore mask is zero and no result is
// pending; the RAM needs no clearing since only filled entries are read.
module signal_pending_queue_core #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int SIGNAL_COUNT = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  spq_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output spq_pkg::out_item_t             m_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spq_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::state_t state_reg, state_next;

    logic [spq_pkg::OP_W-1:0]       op_reg, op_next;
    logic [spq_pkg::SIG_W-1:0]      sig_reg, sig_next;
    logic                           ok_reg, ok_next;
    logic [PTR_W-1:0]               head_reg, head_next;
    logic [PTR_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [PTR_W-1:0]               scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic                           dup_reg, dup_next;
    logic                           live_reg, live_next;
    logic [spq_pkg::SIG_W-1:0]      taken_reg, taken_next;
    logic                           queued_reg, queued_next;
    logic [spq_pkg::APB_DATA_W-1:0] mask_reg, mask_next;
    logic                           m_valid_reg, m_valid_next;
    spq_pkg::out_item_t             m_item_reg, m_item_next;

    logic                           ram_we;
    logic [PTR_W-1:0]               ram_waddr;
    logic [spq_pkg::SIG_W-1:0]      ram_wdata;
    logic [PTR_W-1:0]               ram_raddr;
    logic [spq_pkg::SIG_W-1:0]      ram_rdata;

    logic                           scan_done;
    logic                           sig_in_range;
    logic                           out_free;
    logic [CNT_W+3:0]               count_ext;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    spq_ram #(
        .WIDTH(spq_pkg::SIG_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready   = (state_reg == spq_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == spq_pkg::REG_IGNORE_MASK) ? mask_reg : '0;

    assign scan_done    = (idx_reg == count_reg) && !rd_valid_reg;
    assign sig_in_range = (s_item.signal_number != '0) &&
                          ({2'b00, s_item.signal_number} < 7'(SIGNAL_COUNT));
    assign out_free     = !m_valid_reg || m_ready;
    assign count_ext    = {4'b0000, count_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_item.operation == spq_pkg::OP_TAKE) ?
                                 spq_pkg::ST_POP_RD : spq_pkg::ST_SCAN;
                end
            end
            spq_pkg::ST_POP_RD: begin
                state_next = (count_reg == '0) ? spq_pkg::ST_SCAN : spq_pkg::ST_POP_CHK;
            end
            spq_pkg::ST_POP_CHK: begin
                state_next = mask_reg[ram_rdata] ? spq_pkg::ST_POP_RD : spq_pkg::ST_SCAN;
            end
            spq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = (op_reg == spq_pkg::OP_QUEUE && ok_reg && !dup_reg) ?
                                 spq_pkg::ST_WRITE : spq_pkg::ST_DONE;
                end
            end
            spq_pkg::ST_WRITE: begin
                state_next = spq_pkg::ST_DONE;
            end
            spq_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        sig_next      = sig_reg;
        ok_next       = ok_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        dup_next      = dup_reg;
        live_next     = live_reg;
        taken_next    = taken_reg;
        queued_next   = queued_reg;
        mask_next     = mask_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        ram_we        = 1'b0;
        ram_waddr     = tail_reg;
        ram_wdata     = sig_reg;
        ram_raddr     = scan_ptr_reg;

        if (psel && penable && pwrite && paddr[2] == spq_pkg::REG_IGNORE_MASK) begin
            mask_next = pwdata;
        end

        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_item.operation;
                    sig_next    = s_item.signal_number;
                    ok_next     = sig_in_range && (count_reg != CNT_W'(QUEUE_DEPTH));
                    taken_next  = '0;
                    queued_next = 1'b0;
                end
            end
            spq_pkg::ST_POP_RD: begin
                ram_raddr = head_reg;
            end
            spq_pkg::ST_POP_CHK: begin
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - CNT_W'(1);
                if (!mask_reg[ram_rdata]) begin
                    taken_next = ram_rdata;
                end
            end
            spq_pkg::ST_SCAN: begin
                if (rd_valid_reg) begin
                    dup_next  = dup_reg || (ram_rdata == sig_reg);
                    live_next = live_reg || !mask_reg[ram_rdata];
                end
                if (idx_reg < count_reg) begin
                    ram_raddr     = scan_ptr_reg;
                    rd_valid_next = 1'b1;
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            spq_pkg::ST_WRITE: begin
                ram_we      = 1'b1;
                tail_next   = ptr_inc(tail_reg);
                count_next  = count_reg + CNT_W'(1);
                queued_next = 1'b1;
                live_next   = live_reg || !mask_reg[sig_reg];
            end
            spq_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_item_next.queued        = queued_reg;
                    m_item_next.taken_signal  = taken_reg;
                    m_item_next.has_pending   = live_reg;
                    m_item_next.pending_total = count_ext[spq_pkg::TOTAL_W-1:0];
                end
            end
            default: begin
            end
        endcase

        if (state_next == spq_pkg::ST_SCAN && state_reg != spq_pkg::ST_SCAN) begin
            scan_ptr_next = head_next;
            idx_next      = '0;
            dup_next      = 1'b0;
            live_next     = 1'b0;
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spq_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            mask_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            mask_reg     <= mask_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sig_reg      <= sig_next;
        ok_reg       <= ok_next;
        scan_ptr_reg <= scan_ptr_next;
        idx_reg      <= idx_next;
        dup_reg      <= dup_next;
        live_reg     <= live_next;
        taken_reg    <= taken_next;
        queued_reg   <= queued_next;
        m_item_reg   <= m_item_next;
    end

endmodule

@@ design/spq_checker.sv @@
// Port-level checker for the pending signal queue, bound to the top level.
// Depends on spq_pkg and signal_pending_queue_core.
module spq_checker #(
    parameter int QUEUE_DEPTH = 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input spq_pkg::out_item_t             m_item
);

    localparam logic SMALL_QUEUE = (QUEUE_DEPTH < 16);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("A stalled result item changed or vanished.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A new item was offered acceptance while one was in work.");

    a_pending_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        SMALL_QUEUE && m_valid && m_item.has_pending |-> m_item.pending_total != '0)
        else $error("A live signal was reported with an empty queue.");

    a_queued_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        SMALL_QUEUE && m_valid && m_item.queued |-> m_item.pending_total != '0)
        else $error("A stored signal left the queue empty.");

    a_take_not_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.taken_signal != '0 |-> !m_item.queued)
        else $error("One item both stored and returned a signal.");

endmodule

bind signal_pending_queue_core spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
